/* sv/dvrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Shared sizes, codes and types for the route table core and its parts.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int NODE_W    = 7;
    localparam int DIST_W    = 8;

    localparam logic [DIST_W-1:0] UNREACH  = 8'd255;
    localparam logic [DIST_W-1:0] DIST_MAX = 8'd254;
    localparam logic [DIST_W-1:0] DIST_ONE = 8'd1;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(MAX_NODES);

    typedef enum logic [1:0] {
        ACT_INIT = 2'd0,
        ACT_LINK = 2'd1,
        ACT_ADV  = 2'd2,
        ACT_READ = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
    } t_in;

    typedef struct packed {
        logic                status;
        logic                reachable;
        logic [DIST_W-1:0]   hop_distance;
        logic [NODE_W-1:0]   next_hop;
    } t_out;

    typedef struct packed {
        logic [DIST_W-1:0]   cost;
        logic [NODE_W-1:0]   hop;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clr_step;
        logic link_wr0;
        logic link_wr1;
        logic adv_start;
        logic adv_step;
        logic read_issue;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    bad;
        logic    clr_last;
        logic    col_last;
    } t_dp_sts;

endpackage

/* sv/dvrt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table datapath
// Holds the table memory, the node count, the item and result registers and
// the merge pipeline for advertisements.
// ----------------------------------------------------------------------------
module dvrt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dvrt_pkg::NODE_W-1:0]   i_cfg_data,
    input  dvrt_pkg::t_in                 i_in,
    input  dvrt_pkg::t_dp_cmd             i_cmd,
    output dvrt_pkg::t_dp_sts             o_sts,
    output dvrt_pkg::t_out                o_out
);
    import dvrt_pkg::*;

    logic [NODE_W-1:0] r_node_count;
    t_in               r_item;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pcol;
    t_entry            mem [DEPTH];
    t_entry            r_rd0;
    t_entry            r_rd1;
    t_out              r_out;
    t_out              n_out;

    logic [NODE_W-1:0] eff;
    logic [NODE_W-1:0] eff_m1;
    logic [NODE_W-1:0] a_m1;
    logic [NODE_W-1:0] b_m1;
    logic [IDX_W-1:0]  ia;
    logic [IDX_W-1:0]  ib;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  crow;
    logic [IDX_W-1:0]  ccol;
    logic              a_ok;
    logic              b_ok;
    logic              bad;
    logic [DIST_W-1:0] cand;
    logic              skip;
    logic              better;
    logic              tie;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_entry            wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;

    // Node number checks against the effective node count.
    assign eff    = (r_node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_node_count;
    assign eff_m1 = eff - NODE_W'(1);
    assign a_ok   = (r_item.node_a != '0) && (r_item.node_a <= eff);
    assign b_ok   = (r_item.node_b != '0) && (r_item.node_b <= eff);
    assign a_m1   = r_item.node_a - NODE_W'(1);
    assign b_m1   = r_item.node_b - NODE_W'(1);
    assign ia     = a_m1[IDX_W-1:0];
    assign ib     = b_m1[IDX_W-1:0];
    assign col    = r_cnt[IDX_W-1:0];
    assign crow   = r_cnt[ADDR_W-1:IDX_W];
    assign ccol   = r_cnt[IDX_W-1:0];

    always_comb begin
        case (r_item.action)
            ACT_INIT: bad = 1'b0;
            ACT_LINK: bad = !(a_ok && b_ok) || (r_item.node_a == r_item.node_b);
            ACT_ADV:  bad = !(a_ok && b_ok) || (r_item.node_a == r_item.node_b);
            ACT_READ: bad = !(a_ok && b_ok);
            default:  bad = 1'b1;
        endcase
    end

    assign o_sts.action   = r_item.action;
    assign o_sts.bad      = bad;
    assign o_sts.clr_last = &r_cnt;
    assign o_sts.col_last = (NODE_W'(col) == eff_m1);

    // Merge of one column: sender entry in r_rd0, receiver entry in r_rd1.
    assign cand   = (r_rd0.cost >= DIST_MAX) ? DIST_MAX : (r_rd0.cost + DIST_ONE);
    assign skip   = (r_pcol == ia) || (r_pcol == ib) || (r_rd0.cost == UNREACH);
    assign better = (r_rd1.cost == UNREACH) || (cand < r_rd1.cost);
    assign tie    = (cand == r_rd1.cost) && (r_rd1.hop > r_item.node_a);

    // One write port shared by the clear sweep, link writes and merges.
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = '0;
        if (i_cmd.clr_step) begin
            we = 1'b1;
            if (crow == ccol) begin
                wdata.cost = '0;
                wdata.hop  = NODE_W'(crow) + NODE_W'(1);
            end else begin
                wdata.cost = UNREACH;
                wdata.hop  = '0;
            end
        end else if (i_cmd.link_wr0) begin
            we    = 1'b1;
            waddr = {ia, ib};
            wdata = '{cost: DIST_ONE, hop: r_item.node_b};
        end else if (i_cmd.link_wr1) begin
            we    = 1'b1;
            waddr = {ib, ia};
            wdata = '{cost: DIST_ONE, hop: r_item.node_a};
        end else if (r_pv && !skip && (better || tie)) begin
            we    = 1'b1;
            waddr = {ib, r_pcol};
            wdata = '{cost: cand, hop: r_item.node_a};
        end
    end

    assign rd_en  = i_cmd.adv_step || i_cmd.read_issue;
    assign raddr0 = i_cmd.read_issue ? {ia, ib} : {ia, col};
    assign raddr1 = {ib, col};

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd0 <= mem[raddr0];
            r_rd1 <= mem[raddr1];
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.clr_start || i_cmd.adv_start) begin
            n_cnt = '0;
        end else if (i_cmd.clr_step || i_cmd.adv_step) begin
            n_cnt = r_cnt + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_cnt        <= '0;
            r_pv         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            r_cnt <= n_cnt;
            r_pv  <= i_cmd.adv_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcol <= col;
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.status = bad;
        if ((r_item.action == ACT_READ) && !bad && (r_rd0.cost != UNREACH)) begin
            n_out.reachable    = 1'b1;
            n_out.hop_distance = r_rd0.cost;
            n_out.next_hop     = r_rd0.hop;
        end
    end

    assign o_out = r_out;

endmodule

/* sv/dvrt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table controller
// Sequences clear sweeps, link writes, advertisement walks and reads, and
// owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module dvrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  dvrt_pkg::t_dp_sts  i_sts,
    output dvrt_pkg::t_dp_cmd  o_cmd
);
    import dvrt_pkg::*;

    typedef enum logic [7:0] {
        S_RCLR = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DISP = 8'b0000_0100,
        S_CLR  = 8'b0000_1000,
        S_LINK = 8'b0001_0000,
        S_ADV  = 8'b0010_0000,
        S_ADVE = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RCLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (i_sts.action)
                    ACT_INIT: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLR;
                    end
                    ACT_LINK: begin
                        if (!i_sts.bad) begin
                            o_cmd.link_wr0 = 1'b1;
                            n_state        = S_LINK;
                        end
                    end
                    ACT_ADV: begin
                        if (!i_sts.bad) begin
                            o_cmd.adv_start = 1'b1;
                            n_state         = S_ADV;
                        end
                    end
                    ACT_READ: begin
                        o_cmd.read_issue = !i_sts.bad;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                o_cmd.link_wr1 = 1'b1;
                n_state        = S_DONE;
            end
            S_ADV: begin
                o_cmd.adv_step = 1'b1;
                if (i_sts.col_last) begin
                    n_state = S_ADVE;
                end
            end
            S_ADVE: begin
                // The last column's merge write lands in this cycle.
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RCLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/distance_vector_route_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table core
// Hop-count routing table with init, link, advertisement merge and read.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   --------  ---------  ----------------------  --------------------------
//   in        input      i_in_valid/o_in_ready   t_in: action, node_a, node_b
//   out       output     o_out_valid/i_out_ready t_out: status, reachable,
//                                                 hop_distance, next_hop
//   cfg       input      i_cfg_we (no wait)      i_cfg_data: node_count
//
// Sequencing: after a transaction is accepted, a read or a rejected item goes
// straight to the result register, a link first writes both directions, and
// an advertisement walks the receiver's row at one column per cycle through
// the two-read, one-write table memory. Init runs the clear sweep over all
// 4096 entries at one entry a cycle.
// Reset: after the synchronous reset releases, the same clear sweep runs,
// during which no input transaction is accepted.
// Stalls: a finished result waits in the output register; a new input is
// accepted meanwhile and only its result waits if the register is still full.
// ----------------------------------------------------------------------------
module distance_vector_route_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dvrt_pkg::NODE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dvrt_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dvrt_pkg::t_out                o_out
);
    import dvrt_pkg::*;

    // Command and status bundles between the controller and the datapath.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller decides the sequence of memory operations per action;
    // it never looks at payload bits except through the status bundle.
    dvrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the 4096-entry table, the node count register and
    // the one-stage read-compare-write pipeline used by advertisements.
    dvrt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

    // An accepted transaction drops ready until its result is loaded into the output register.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an accepted transaction");

    // At most one table operation is commanded in any cycle.
    a_one_table_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.link_wr0, cmd.link_wr1, cmd.adv_step,
                  cmd.read_issue}))
        else $error("more than one table operation commanded");

    // A result is loaded only when the output register is free or draining.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over a pending output");

    // A capture only happens on an accepted transaction.
    a_capture_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> (i_in_valid && o_in_ready))
        else $error("input captured without an accepted transaction");

endmodule

/* tb/sv/tb_distance_vector_route_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table core testbench
// Drives init, link, advertisement and read transactions into the route
// table core under several node counts, with random gaps on the input side
// and random back-pressure on the output side. A scoreboard keeps its own
// copy of the hop-count table, predicts one result per accepted transaction
// and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_table_core;

    import dvrt_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow of the routing table plus the queue of results
    // that the core still owes us.
    // ------------------------------------------------------------------------
    class route_scoreboard;
        bit [DIST_W-1:0] dist_tbl [MAX_NODES][MAX_NODES];
        bit [NODE_W-1:0] hop_tbl  [MAX_NODES][MAX_NODES];
        bit [NODE_W-1:0] node_count;
        t_out            owed_q [$];
        int              mismatches;

        function new();
            node_count = NODE_COUNT_RST;
            mismatches = 0;
            clear_table();
        endfunction

        function void clear_table();
            for (int r = 0; r < MAX_NODES; r++) begin
                for (int c = 0; c < MAX_NODES; c++) begin
                    dist_tbl[r][c] = (r == c) ? 8'd0 : UNREACH;
                    hop_tbl[r][c]  = (r == c) ? NODE_W'(r + 1) : '0;
                end
            end
        endfunction

        // Counts above the table size behave as the table size.
        function int live_nodes();
            return (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        endfunction

        function bit node_valid(logic [NODE_W-1:0] n);
            return (n >= 1) && (int'(n) <= live_nodes());
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Bellman-Ford relaxation of the receiver row through the sender.
        // Both arguments are zero-based row numbers.
        function void merge_row(int snd, int rcv);
            int cand;
            for (int c = 0; c < live_nodes(); c++) begin
                if (c == snd || c == rcv || dist_tbl[snd][c] == UNREACH)
                    continue;
                cand = int'(dist_tbl[snd][c]) + 1;
                if (cand > DIST_MAX)
                    cand = DIST_MAX;
                if (dist_tbl[rcv][c] == UNREACH || cand < dist_tbl[rcv][c]) begin
                    dist_tbl[rcv][c] = DIST_W'(cand);
                    hop_tbl[rcv][c]  = NODE_W'(snd + 1);
                end else if (cand == dist_tbl[rcv][c] && hop_tbl[rcv][c] > snd + 1) begin
                    // Equal cost: the lower-numbered sender wins.
                    hop_tbl[rcv][c] = NODE_W'(snd + 1);
                end
            end
        endfunction

        // Called once per accepted input transaction.
        function void note_input(t_in item);
            t_out res;
            bit   both_ok;
            int   ia;
            int   ib;
            res     = '0;
            both_ok = node_valid(item.node_a) && node_valid(item.node_b);
            ia      = int'(item.node_a) - 1;
            ib      = int'(item.node_b) - 1;
            case (item.action)
                ACT_INIT: begin
                    clear_table();
                end
                ACT_LINK, ACT_ADV: begin
                    if (!both_ok || item.node_a == item.node_b) begin
                        res.status = 1'b1;
                    end else if (item.action == ACT_LINK) begin
                        dist_tbl[ia][ib] = DIST_ONE;
                        hop_tbl[ia][ib]  = item.node_b;
                        dist_tbl[ib][ia] = DIST_ONE;
                        hop_tbl[ib][ia]  = item.node_a;
                    end else begin
                        merge_row(ia, ib);
                    end
                end
                default: begin
                    if (!both_ok) begin
                        res.status = 1'b1;
                    end else if (dist_tbl[ia][ib] != UNREACH) begin
                        res.reachable    = 1'b1;
                        res.hop_distance = dist_tbl[ia][ib];
                        res.next_hop     = hop_tbl[ia][ib];
                    end
                end
            endcase
            owed_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Called once per accepted output transaction.
        function void check_result(t_out got);
            t_out want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("reachable", 8'(want.reachable), 8'(got.reachable));
            compare_field("hop_distance", want.hop_distance, got.hop_distance);
            compare_field("next_hop", 8'(want.next_hop), 8'(got.next_hop));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals toward the core. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [NODE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in               i_in        = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out              o_out;

    // When set, both sides run without gaps or stalls for a whole phase.
    bit                calm        = 1'b0;

    route_scoreboard   sb          = new();

    // Node counts for the random phases: normal sizes, the smallest legal
    // count, zero (every node invalid) and counts above the table size.
    int                count_plan [10] = '{64, 8, 1, 0, 127, 3, 100, 2, 16, 64};

    localparam int ITEMS_PER_PHASE = 115;

    distance_vector_route_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Output back-pressure: ready drops in about a quarter of the cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // Every accepted result goes straight to the scoreboard. Values read here
    // are the ones that were present at the edge itself.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in req(t_action act, int a, int b);
        t_in item;
        item.action = act;
        item.node_a = NODE_W'(a);
        item.node_b = NODE_W'(b);
        return item;
    endfunction

    // Mostly valid node numbers, with a bias toward a small cluster so that
    // links and advertisements build multi-hop routes and equal-cost ties.
    // The rest spans the whole field, zero and out-of-range values included.
    function automatic logic [NODE_W-1:0] random_node(int live);
        int roll;
        roll = $urandom_range(0, 99);
        if (live == 0 || roll < 12)
            return NODE_W'($urandom_range(0, 127));
        if (roll < 50)
            return NODE_W'($urandom_range(1, (live < 8) ? live : 8));
        return NODE_W'($urandom_range(1, live));
    endfunction

    // Init is kept rare because it costs a full sweep of the table.
    function automatic t_in random_item();
        t_in item;
        int  roll;
        roll        = $urandom_range(0, 99);
        item.action = (roll < 1)  ? ACT_INIT :
                      (roll < 31) ? ACT_LINK :
                      (roll < 66) ? ACT_ADV  : ACT_READ;
        item.node_a = random_node(sb.live_nodes());
        item.node_b = random_node(sb.live_nodes());
        return item;
    endfunction

    // Presents one transaction and holds it until the core takes it. A gap
    // before the transaction lowers valid at the step of the previous
    // acceptance; without a gap valid simply stays high.
    task automatic send_item(input t_in item);
        if (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(item);
    endtask

    // Stops the input side and waits until every owed result has arrived.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // The register may only change while the core is idle: nothing owed and
    // the input side ready again.
    task automatic set_node_count(input int value);
        while (!o_in_ready) @(posedge i_clk);
        i_cfg_data <= NODE_W'(value);
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.node_count = NODE_W'(value);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The clear sweep after reset holds ready low; waiting on ready here
        // keeps the first write out of the sweep.
        set_node_count(64);

        // Directed part. Reads of the diagonal and of an empty entry, reads
        // and links and advertisements with zero, out-of-range and equal
        // node numbers, then a small graph that forces an equal-cost tie.
        send_item(req(ACT_READ, 1, 1));
        send_item(req(ACT_READ, 1, 2));
        send_item(req(ACT_READ, 0, 5));
        send_item(req(ACT_READ, 65, 1));
        send_item(req(ACT_READ, 127, 127));
        send_item(req(ACT_READ, 64, 64));
        send_item(req(ACT_LINK, 1, 1));
        send_item(req(ACT_LINK, 0, 3));
        send_item(req(ACT_LINK, 2, 65));
        send_item(req(ACT_ADV, 5, 5));
        send_item(req(ACT_ADV, 127, 4));
        send_item(req(ACT_LINK, 1, 64));
        // Square 10-11-13-12-10: node 10 reaches 13 through 11 or 12 at
        // equal cost.
        send_item(req(ACT_LINK, 10, 11));
        send_item(req(ACT_LINK, 10, 12));
        send_item(req(ACT_LINK, 11, 13));
        send_item(req(ACT_LINK, 12, 13));
        send_item(req(ACT_ADV, 12, 10));
        // Same cost through 11: the next hop must switch to the lower sender.
        send_item(req(ACT_ADV, 11, 10));
        send_item(req(ACT_READ, 10, 13));
        send_item(req(ACT_ADV, 10, 1));
        send_item(req(ACT_READ, 1, 13));
        // A link overwrites a longer learned route.
        send_item(req(ACT_LINK, 13, 10));
        send_item(req(ACT_READ, 10, 13));
        // Init ignores its node fields and wipes every learned route.
        send_item(req(ACT_INIT, 127, 0));
        send_item(req(ACT_READ, 10, 13));
        drain();

        // Random phases. The saturation cap at 254 hops cannot be reached
        // through this interface: routes only ever shrink, so no distance
        // exceeds the longest simple path through the table.
        foreach (count_plan[p]) begin
            set_node_count(count_plan[p]);
            calm <= (p == 1);
            repeat (ITEMS_PER_PHASE) send_item(random_item());
            drain();
        end
        calm <= 1'b0;

        // Give a stray extra result time to show up before the verdict.
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: several times the slowest expected run, including the
    // clear sweeps after reset and after each init.
    initial begin
        #200000000;
        $display("Verification failed");
        $finish;
    end

endmodule
